### rtl/apu_frame_sequencer_unit_defines.svh
// Assertion macros shared by the frame sequencer checker.
`ifndef APU_FRAME_SEQUENCER_UNIT_DEFINES_SVH
`define APU_FRAME_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define APU_FS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame sequencer check failed");

// Next-cycle implication, ignored while reset is high.
`define APU_FS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame sequencer check failed");

// Next-cycle implication that also covers the reset cycles.
`define APU_FS_ASSERT_RST(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("frame sequencer reset check failed");

`endif

### rtl/apu_fs_pkg.sv
// Types and constants of the sound unit frame sequencer.
package apu_fs_pkg;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [4:0] REG_STATUS = 5'h15;
   localparam logic [4:0] REG_FRAME  = 5'h17;

   localparam int BIT_FIVE_STEP   = 7;
   localparam int BIT_IRQ_INHIBIT = 6;

   localparam logic [15:0] STEP_QUARTER_1  = 16'd7457;
   localparam logic [15:0] STEP_HALF_1     = 16'd14913;
   localparam logic [15:0] STEP_QUARTER_3  = 16'd22371;
   localparam logic [15:0] STEP4_IRQ_START = 16'd29828;
   localparam logic [15:0] STEP4_HALF_2    = 16'd29829;
   localparam logic [15:0] STEP4_WRAP      = 16'd29830;
   localparam logic [15:0] STEP5_HALF_2    = 16'd37281;
   localparam logic [15:0] STEP5_WRAP      = 16'd37282;

   localparam logic [7:0] READ_OPEN_BUS = 8'hFF;

   typedef struct packed {
      logic [1:0] op;
      logic [4:0] reg_offset;
      logic [7:0] write_value;
      logic [3:0] length_active;
   } req_item_type;

   typedef struct packed {
      logic       quarter_frame;
      logic       half_frame;
      logic       pulse_timer_tick;
      logic       irq_line;
      logic [7:0] read_data;
      logic [3:0] length_clear;
      logic [3:0] channel_enable;
   } rsp_item_type;

endpackage

### rtl/apu_fs_core.sv
// Frame sequencer state and the per-word update logic.
module apu_fs_core
   import apu_fs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [15:0] frame_cycle_ff, frame_cycle_in;
   logic        five_step_ff, five_step_in;
   logic        irq_inhibit_ff, irq_inhibit_in;
   logic        irq_flag_ff, irq_flag_in;
   logic [3:0]  enable_mask_ff, enable_mask_in;
   logic        parity_ff, parity_in;
   logic [15:0] fc_inc;

   assign fc_inc = frame_cycle_ff + 16'd1;

   always_comb begin
      frame_cycle_in = frame_cycle_ff;
      five_step_in   = five_step_ff;
      irq_inhibit_in = irq_inhibit_ff;
      irq_flag_in    = irq_flag_ff;
      enable_mask_in = enable_mask_ff;
      parity_in      = parity_ff;
      result         = '0;
      case (item.op)
         OP_TICK: begin
            frame_cycle_in = fc_inc;
            result.quarter_frame = (fc_inc == STEP_QUARTER_1) || (fc_inc == STEP_HALF_1) ||
                                   (fc_inc == STEP_QUARTER_3);
            result.half_frame    = (fc_inc == STEP_HALF_1);
            if (!five_step_ff) begin
               if (fc_inc == STEP4_HALF_2) begin
                  result.quarter_frame = 1'b1;
                  result.half_frame    = 1'b1;
               end
               // The flag is raised from STEP4_IRQ_START to frame end.
               if ((fc_inc >= STEP4_IRQ_START) && !irq_inhibit_ff) begin
                  irq_flag_in = 1'b1;
               end
               if (fc_inc >= STEP4_WRAP) begin
                  frame_cycle_in = '0;
               end
            end else begin
               if (fc_inc == STEP5_HALF_2) begin
                  result.quarter_frame = 1'b1;
                  result.half_frame    = 1'b1;
               end
               if (fc_inc >= STEP5_WRAP) begin
                  frame_cycle_in = '0;
               end
            end
            result.pulse_timer_tick = !parity_ff;
            parity_in = !parity_ff;
         end
         OP_WRITE: begin
            if (item.reg_offset == REG_STATUS) begin
               result.length_clear = enable_mask_ff & ~item.write_value[3:0];
               enable_mask_in      = item.write_value[3:0];
            end else if (item.reg_offset == REG_FRAME) begin
               five_step_in   = item.write_value[BIT_FIVE_STEP];
               irq_inhibit_in = item.write_value[BIT_IRQ_INHIBIT];
               if (item.write_value[BIT_IRQ_INHIBIT]) begin
                  irq_flag_in = 1'b0;
               end
               frame_cycle_in = '0;
               // Entering five-step mode clocks both units at once.
               if (item.write_value[BIT_FIVE_STEP]) begin
                  result.quarter_frame = 1'b1;
                  result.half_frame    = 1'b1;
               end
            end
         end
         OP_READ: begin
            if (item.reg_offset == REG_STATUS) begin
               result.read_data = {1'b0, irq_flag_ff, 2'b00, item.length_active};
               irq_flag_in      = 1'b0;
            end else begin
               result.read_data = READ_OPEN_BUS;
            end
         end
         default: begin
         end
      endcase
      result.irq_line       = irq_flag_in;
      result.channel_enable = enable_mask_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_cycle_ff <= '0;
         five_step_ff   <= 1'b0;
         irq_inhibit_ff <= 1'b0;
         irq_flag_ff    <= 1'b0;
         enable_mask_ff <= '0;
         parity_ff      <= 1'b0;
      end else if (step) begin
         frame_cycle_ff <= frame_cycle_in;
         five_step_ff   <= five_step_in;
         irq_inhibit_ff <= irq_inhibit_in;
         irq_flag_ff    <= irq_flag_in;
         enable_mask_ff <= enable_mask_in;
         parity_ff      <= parity_in;
      end
   end

endmodule

### rtl/apu_frame_sequencer_unit.sv
// Top level of the frame sequencer: input register, update logic, result register.
// Frame sequencer of the sound unit with its status and frame control registers. Each
// word is a CPU-cycle tick, a register write or a register read, and gives exactly one
// result word. One word is taken per clock cycle when the result side keeps up; an
// accepted word waits in the input register until the result register is free, then
// moves into it, and its result is valid from then on. A stalled result side is
// absorbed by the input register, so req_ready only drops once both registers hold
// waiting words.
module apu_frame_sequencer_unit
   import apu_fs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic [4:0] req_reg_offset,
   input  logic [7:0] req_write_value,
   input  logic [3:0] req_length_active,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_quarter_frame,
   output logic       rsp_half_frame,
   output logic       rsp_pulse_timer_tick,
   output logic       rsp_irq_line,
   output logic [7:0] rsp_read_data,
   output logic [3:0] rsp_length_clear,
   output logic [3:0] rsp_channel_enable
);

   logic         stage_valid_ff, stage_valid_in;
   req_item_type stage_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type core_result;
   logic         out_free;
   logic         stage_move;
   logic         req_take;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign stage_move = stage_valid_ff && out_free;
   assign req_ready  = !stage_valid_ff || out_free;
   assign req_take   = req_valid && req_ready;

   assign stage_valid_in = req_take || (stage_valid_ff && !stage_move);
   assign rsp_valid_in   = stage_move || (rsp_valid_ff && !rsp_ready);

   apu_fs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (stage_move),
      .item   (stage_item_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_item_ff <= '{op: req_op, reg_offset: req_reg_offset,
                            write_value: req_write_value, length_active: req_length_active};
      end
      if (stage_move) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_quarter_frame    = rsp_item_ff.quarter_frame;
   assign rsp_half_frame       = rsp_item_ff.half_frame;
   assign rsp_pulse_timer_tick = rsp_item_ff.pulse_timer_tick;
   assign rsp_irq_line         = rsp_item_ff.irq_line;
   assign rsp_read_data        = rsp_item_ff.read_data;
   assign rsp_length_clear     = rsp_item_ff.length_clear;
   assign rsp_channel_enable   = rsp_item_ff.channel_enable;

endmodule

### rtl/apu_fs_checker.sv
// Port-level checks of the frame sequencer, bound to its top level.
`include "apu_frame_sequencer_unit_defines.svh"

module apu_fs_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_quarter_frame,
   input logic       rsp_half_frame,
   input logic [7:0] rsp_read_data,
   input logic [3:0] rsp_length_clear,
   input logic [3:0] rsp_channel_enable
);

   // A half-frame point is always also a quarter-frame point.
   `APU_FS_ASSERT_NOW(half_has_quarter, rsp_valid && rsp_half_frame, rsp_quarter_frame)

   // A cleared length counter belongs to a channel that is now disabled.
   `APU_FS_ASSERT_NOW(clear_means_disabled, rsp_valid && (rsp_length_clear != 4'd0),
                      (rsp_length_clear & rsp_channel_enable) == 4'd0)

   // A stalled result word holds.
   `APU_FS_ASSERT_NEXT(rsp_hold, rsp_valid && !rsp_ready,
                       rsp_valid && $stable(rsp_read_data) && $stable(rsp_channel_enable))

   // No result word is offered right after reset.
   `APU_FS_ASSERT_RST(reset_clears_rsp, reset, !rsp_valid)

endmodule

bind apu_frame_sequencer_unit apu_fs_checker u_apu_fs_checker (.*);
